### src/fpr_pkg.sv
// Shared types and constants of the FIFO page replacement unit.
`default_nettype none
package fpr_pkg;

  localparam int FRAME_SLOTS_DEF = 16;
  localparam int PAGE_W          = 16;
  localparam int COUNT_W         = 32;
  localparam int CFG_W           = 5;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 56;

  localparam logic [CFG_W-1:0]      NUM_FRAMES_RST = 5'd16;
  localparam logic [APB_ADDR_W-1:0] ADDR_NUM_FRAMES = 3'd0;
  localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [0:0] {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } fpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } fpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } fpr_status_t;

endpackage
`default_nettype wire

### src/fpr_ctrl.sv
// Controller state machine of the FIFO page replacement unit.
`default_nettype none
module fpr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             out_ready,
  input  wire fpr_pkg::fpr_status_t status,
  output logic                  in_ready,
  output fpr_pkg::fpr_cmd_t     cmd
);
  import fpr_pkg::*;

  fpr_state_t state;
  fpr_state_t state_next;
  logic       take_ok;

  // The captured reference is applied once the result register is free or being emptied.
  assign take_ok = !status.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (take_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_APPLY: begin
        cmd.apply = take_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/fpr_datapath.sv
// Datapath: resident page store, lookup, eviction and fault counting.
`default_nettype none
module fpr_datapath #(
  parameter int FRAME_SLOTS = fpr_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fpr_pkg::fpr_cmd_t             cmd,
  input  wire logic [fpr_pkg::CFG_W-1:0]     num_frames,
  input  wire logic [fpr_pkg::PAGE_W-1:0]    page_in,
  input  wire logic                          out_ready,
  output fpr_pkg::fpr_status_t               status,
  output logic                               out_valid,
  output logic                               hit,
  output logic [fpr_pkg::COUNT_W-1:0]        fault_total,
  output logic                               evicted_valid,
  output logic [fpr_pkg::PAGE_W-1:0]         evicted_page
);
  import fpr_pkg::*;

  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int OCC_W  = $clog2(FRAME_SLOTS + 1);
  localparam int CMP_W  = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;
  localparam int SUM_W  = OCC_W + 1;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(FRAME_SLOTS);
  localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(FRAME_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic [PAGE_W-1:0]  frame_pages [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] frame_valid;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [OCC_W-1:0]   occupancy;
  logic [COUNT_W-1:0] fault_count;
  logic [PAGE_W-1:0]  page;

  logic [FRAME_SLOTS-1:0] match;
  logic               is_hit;
  logic [CMP_W-1:0]   nf_ext;
  logic [CMP_W-1:0]   eff_frames;
  logic               do_evict;
  logic [SUM_W-1:0]   tail_sum;
  logic [SLOT_W-1:0]  tail_slot;
  logic [SLOT_W-1:0]  oldest_inc;
  logic [COUNT_W-1:0] fault_count_next;

  // Every valid frame is compared against the reference at once.
  always_comb begin
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      match[i] = frame_valid[i] && (frame_pages[i] == page);
    end
  end
  assign is_hit = |match;

  always_comb begin
    nf_ext = CMP_W'(num_frames);
    if (nf_ext == '0) begin
      eff_frames = CMP_W'(1);
    end else if (nf_ext > SLOTS_C) begin
      eff_frames = SLOTS_C;
    end else begin
      eff_frames = nf_ext;
    end
  end

  assign do_evict = (CMP_W'(occupancy) >= eff_frames) && (occupancy != '0);

  // The new page lands at oldest plus occupancy, with or without an eviction.
  always_comb begin
    tail_sum = SUM_W'(oldest_slot) + SUM_W'(occupancy);
    if (tail_sum >= SLOTS_S) begin
      tail_sum = tail_sum - SLOTS_S;
    end
    tail_slot = tail_sum[SLOT_W-1:0];
  end

  assign oldest_inc = (oldest_slot == LAST_SLOT) ? '0 : oldest_slot + SLOT_W'(1);
  assign fault_count_next = (fault_count == COUNT_MAX) ? fault_count
                                                       : fault_count + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page <= page_in;
    end
    if (cmd.apply) begin
      hit <= is_hit;
      if (is_hit) begin
        fault_total   <= fault_count;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else begin
        fault_total   <= fault_count_next;
        evicted_valid <= do_evict;
        evicted_page  <= do_evict ? frame_pages[oldest_slot] : '0;
        frame_pages[tail_slot] <= page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      oldest_slot <= '0;
      occupancy   <= '0;
      fault_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.apply && !is_hit) begin
        fault_count <= fault_count_next;
        if (do_evict) begin
          // Occupancy is unchanged: one page leaves and one arrives.
          frame_valid[oldest_slot] <= 1'b0;
          oldest_slot <= oldest_inc;
        end else begin
          occupancy <= occupancy + OCC_W'(1);
        end
        frame_valid[tail_slot] <= 1'b1;
      end
    end
  end

  assign status.out_valid = out_valid;

endmodule
`default_nettype wire

### src/fifo_page_replacement_unit.sv
// Top level of the FIFO page replacement unit: stream ports and register port.
//
//  Channel   Direction  Contents
//  s_axis    in         one page reference per transaction
//  m_axis    out        one result per reference: hit, fault count, eviction
//  apb       in/out     num_frames register at byte address 0
//
// Each reference is first captured, then goes through the parallel lookup and
// the store update, which also loads the result register.
// A reference is captured while a result waits; it then holds in the capture
// register until the result register is empty or being emptied in that cycle.
// Reset clears the frame valid bits, pointers, fault count and sets num_frames
// to 16; a stalled result holds its register until it is taken.
`default_nettype none
module fifo_page_replacement_unit #(
  parameter int FRAME_SLOTS = fpr_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] page_id
  input  wire logic [fpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] hit, [32:1] fault_total, [33] evicted_valid, [49:34] evicted_page,
  // [55:50] zero
  output logic [fpr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fpr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [fpr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fpr_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import fpr_pkg::*;

  logic [CFG_W-1:0]   num_frames;
  fpr_cmd_t           cmd;
  fpr_status_t        status;
  logic               hit;
  logic [COUNT_W-1:0] fault_total;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RST;
    end else if (cfg_write && (paddr == ADDR_NUM_FRAMES)) begin
      num_frames <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_NUM_FRAMES) ? APB_DATA_W'(num_frames) : '0;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .in_ready  (s_axis_tready),
    .cmd       (cmd)
  );

  fpr_datapath #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .num_frames    (num_frames),
    .page_in       (s_axis_tdata[PAGE_W-1:0]),
    .out_ready     (m_axis_tready),
    .status        (status),
    .out_valid     (m_axis_tvalid),
    .hit           (hit),
    .fault_total   (fault_total),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
  );

  assign m_axis_tdata = {6'b0, evicted_page, evicted_valid, fault_total, hit};

endmodule
`default_nettype wire

### tb/fpr_checker.sv
// Checker for the FIFO page replacement unit: predicts every result and compares it.
module fpr_checker #(
  parameter int FRAME_SLOTS = fpr_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  input  wire logic [fpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [fpr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic                              pready,
  input  wire logic [fpr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [fpr_pkg::APB_DATA_W-1:0]    pwdata,
  output int                                     mismatches,
  output int                                     outstanding
);
  import fpr_pkg::*;

  // Laid out as on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [COUNT_W-1:0] fault_total;
    logic               hit;
  } page_result_t;

  localparam int RES_W = $bits(page_result_t);

  logic [PAGE_W-1:0]  page_store [FRAME_SLOTS];
  logic               page_live  [FRAME_SLOTS];
  int                 head_slot;
  int                 resident_cnt;
  logic [COUNT_W-1:0] fault_cnt;
  logic [CFG_W-1:0]   frames_reg;
  page_result_t       results_due [$];
  int                 error_total = 0;
  int                 due_cnt = 0;

  assign mismatches  = error_total;
  assign outstanding = due_cnt;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_total++;
  endtask

  // Applies one page reference to the predicted store and returns its result.
  function automatic page_result_t next_result(input logic [PAGE_W-1:0] pg);
    int lim;
    int slot;
    page_result_t r;
    r = '0;
    lim = (frames_reg == '0) ? 1 :
          ((int'(frames_reg) > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_reg));
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (page_live[i] && page_store[i] == pg) r.hit = 1'b1;
    end
    if (!r.hit) begin
      if (fault_cnt != COUNT_MAX) fault_cnt++;
      // A lowered frame count still removes only one page per miss.
      if (resident_cnt >= lim && resident_cnt > 0) begin
        slot = head_slot;
        r.evicted_valid = 1'b1;
        r.evicted_page  = page_store[slot];
        page_live[slot] = 1'b0;
        head_slot = (slot + 1) % FRAME_SLOTS;
        resident_cnt--;
      end
      if (resident_cnt < FRAME_SLOTS) begin
        slot = (head_slot + resident_cnt) % FRAME_SLOTS;
        page_store[slot] = pg;
        page_live[slot]  = 1'b1;
        resident_cnt++;
      end
    end
    r.fault_total = fault_cnt;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    page_result_t got;
    page_result_t want;
    if (rst) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        page_store[i] = '0;
        page_live[i]  = 1'b0;
      end
      head_slot    = 0;
      resident_cnt = 0;
      fault_cnt    = '0;
      frames_reg   = NUM_FRAMES_RST;
      results_due.delete();
    end else begin
      // Results are checked before new references are predicted in the same cycle.
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result with none pending", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = results_due.pop_front();
          got  = m_axis_tdata[RES_W-1:0];
          if (got.hit !== want.hit) flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.fault_total !== want.fault_total)
            flag_mismatch("fault_total", got.fault_total, want.fault_total);
          if (got.evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
          if (got.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
          if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0)
            flag_mismatch("tdata padding", 32'(m_axis_tdata[OUT_TDATA_W-1:RES_W]), 32'd0);
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_NUM_FRAMES)
        frames_reg = pwdata[CFG_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(next_result(s_axis_tdata[PAGE_W-1:0]));
    end
    due_cnt = results_due.size();
  end

endmodule

### tb/tb.sv
// Testbench top of the FIFO page replacement unit: clock, reset, stimulus and verdict.
module tb;
  import fpr_pkg::*;

  // No register is decoded at this address, so writes to it must be ignored.
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 150;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] page_id
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] hit, [32:1] fault_total, [33] evicted_valid, [49:34] evicted_page, [55:50] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int send_idle;
  int recv_idle;
  int hold_reqs;
  int mismatches;
  int outstanding;

  fifo_page_replacement_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  fpr_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_600_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: random back-pressure, plus long hold-offs on request.
  initial begin : recv_side
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly pages from a narrow window so that hits and evictions both occur.
  function automatic logic [PAGE_W-1:0] random_page(input logic [PAGE_W-1:0] base,
                                                    input int span);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return PAGE_W'(32'(base) + $urandom_range(0, span));
    if (pick < 95) return PAGE_W'($urandom_range(0, 16'hFFFF));
    return pick[0] ? 16'hFFFF : 16'h0000;
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0]  cfg_plan [12];
    logic [CFG_W-1:0]  cfg;
    logic [PAGE_W-1:0] base;
    int                span;
    cfg_plan = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd12, 5'd17, 5'd5, 5'd16, 5'd1};
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_reqs     = 0;
    send_idle     = 11;
    recv_idle     = 60;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extreme page numbers, each missed once and then hit.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    // Frame count lowered below the number of resident pages.
    settle();
    write_reg(ADDR_NUM_FRAMES, 32'd1);
    send_page(16'h1234);
    send_page(16'h8001);
    // A frame count of zero behaves as one.
    settle();
    write_reg(ADDR_NUM_FRAMES, 32'd0);
    send_page(16'h0005);
    send_page(16'h0005);
    send_page(16'h8001);
    // A write to an undecoded address leaves the frame count alone.
    settle();
    write_reg(ADDR_SPARE, 32'd16);
    send_page(16'h4242);
    // An oversized frame count is clipped to the store size: fill it.
    settle();
    write_reg(ADDR_NUM_FRAMES, 32'd31);
    for (int i = 0; i < 15; i++) send_page(PAGE_W'(16'h0100 + i));

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle = 11;
          recv_idle = 60;
        end
        1: begin
          send_idle = 60;
          recv_idle = 11;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int p = 0; p < 4; p++) begin
        cfg = cfg_plan[mode * 4 + p];
        settle();
        write_reg(ADDR_NUM_FRAMES, {{(APB_DATA_W - CFG_W){1'b0}}, cfg});
        base = PAGE_W'($urandom_range(0, 16'hFFFF));
        span = ((int'(cfg) > FRAME_SLOTS_DEF) ? FRAME_SLOTS_DEF : int'(cfg)) + 3;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // Stall the result side for a long stretch so that the input backs up.
          if (p == 1 && n == 20) hold_reqs++;
          send_page(random_page(base, span));
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
